// ----- design/ccb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_pkg
// Types and constants shared by the CPU bus block with PPU ports.
// ----------------------------------------------------------------------------
package ccb_pkg;

   localparam int INTERNAL_RAM_BYTES = 2048;
   localparam int PROGRAM_BANK_BYTES = 16384;
   localparam int DMA_STALL_CYCLES   = 513;

   localparam int WRAM_AW = $clog2(INTERNAL_RAM_BYTES);
   localparam int PRG_AW  = $clog2(2 * PROGRAM_BANK_BYTES);
   localparam int CART_AW = 13;
   localparam int PAT_AW  = 13;
   localparam int NT_AW   = 12;
   localparam int PAL_AW  = 5;
   localparam int OAM_AW  = 8;

   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_VBLANK = 2'd2;

   localparam logic [2:0] PREG_CTRL   = 3'd0;
   localparam logic [2:0] PREG_STATUS = 3'd2;
   localparam logic [2:0] PREG_OAMADR = 3'd3;
   localparam logic [2:0] PREG_OAMDAT = 3'd4;
   localparam logic [2:0] PREG_ADDR   = 3'd6;
   localparam logic [2:0] PREG_DATA   = 3'd7;

   localparam logic [15:0] ADDR_OAM_DMA = 16'h4014;
   localparam logic [15:0] ADDR_PAD     = 16'h4016;
   localparam logic [15:0] ADDR_IO_END  = 16'h4020;
   localparam logic [13:0] PPU_PAL_BASE = 14'h3F00;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  buttons;
   } ccb_req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic [9:0] stall_cycles;
      logic       nmi_enable;
      logic       nmi_pending;
   } ccb_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DMA
   } ccb_state_type;

   typedef enum logic [2:0] {
      RG_WRAM,
      RG_PPU,
      RG_IO,
      RG_CART,
      RG_PRG
   } ccb_region_type;

   typedef enum logic [1:0] {
      PR_PAT,
      PR_NT,
      PR_PAL
   } ccb_pregion_type;

   function automatic ccb_region_type cpu_region(input logic [15:0] a);
      ccb_region_type r;
      if (a[15:13] == 3'b000)      r = RG_WRAM;
      else if (a[15:13] == 3'b001) r = RG_PPU;
      else if (a < ADDR_IO_END)    r = RG_IO;
      else if (!a[15])             r = RG_CART;
      else                         r = RG_PRG;
      return r;
   endfunction

   function automatic ccb_pregion_type ppu_region(input logic [15:0] latch);
      ccb_pregion_type r;
      if (!latch[13])                       r = PR_PAT;
      else if (latch[13:0] < PPU_PAL_BASE)  r = PR_NT;
      else                                  r = PR_PAL;
      return r;
   endfunction

   // Bank bit 14 survives only with two banks (a count of 3 acts as 2, 0 as 1)
   function automatic logic [PRG_AW-1:0] prg_index(input logic [15:0] a,
                                                   input logic [1:0] banks);
      logic [PRG_AW-1:0] idx;
      idx = a[PRG_AW-1:0];
      idx[PRG_AW-1] = a[PRG_AW-1] & banks[1];
      return idx;
   endfunction

endpackage

// ----- design/console_cpu_bus_with_ppu_ports.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_cpu_bus_with_ppu_ports
// CPU bus decoder with mirrored RAM, PPU register ports, I/O, work RAM,
// program memory, controller port and OAM DMA.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req     | in        | valid / stall    | cmd, addr, wdata, buttons
//  rsp     | out       | valid / stall    | rdata, stall_cycles, nmi flags
//  csr     | in        | valid / ready    | prg_banks (2 bits)
//
// The idle state accepts a request and issues the synchronous memory reads;
// the execute state executes and writes back. An OAM DMA write walks the
// source page one byte per cycle through the single read port. Reset sets
// the control flip-flops, not the request, response or read data registers;
// RAM, program, pattern, nametable, palette and OAM stores hold garbage until
// written, with no clearing pass. A stalled response holds in the output
// register; the execute step waits until that register is free.
// ----------------------------------------------------------------------------
module console_cpu_bus_with_ppu_ports (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ccb_pkg::ccb_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ccb_pkg::ccb_rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_wdata
);
   import ccb_pkg::*;

   ccb_state_type state_ff, state_in;
   ccb_req_type   cur_ff, cur_in;
   logic [7:0]    ppu_ff [8];
   logic [7:0]    ppu_in [8];
   logic [7:0]    io_ff [32];
   logic [7:0]    io_in [32];
   logic [15:0]   latch_ff, latch_in;
   logic [7:0]    pad_byte_ff, pad_byte_in;
   logic [3:0]    pad_cnt_ff, pad_cnt_in;
   logic          pad_strobe_ff, pad_strobe_in;
   logic          nmi_flag_ff, nmi_flag_in;
   logic          nmi_en_ff, nmi_en_in;
   logic [1:0]    banks_ff;
   logic [8:0]    dma_cnt_ff, dma_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ccb_rsp_type   rsp_ff, rsp_in;
   logic [15:0]   rd_addr_ff;

   logic [7:0] wram_mem [INTERNAL_RAM_BYTES];
   logic [7:0] cart_mem [2**CART_AW];
   logic [7:0] prg_mem  [2 * PROGRAM_BANK_BYTES];
   logic [7:0] pat_mem  [2**PAT_AW];
   logic [7:0] nt_mem   [2**NT_AW];
   logic [7:0] pal_mem  [2**PAL_AW];
   logic [7:0] oam_mem  [2**OAM_AW];
   logic [7:0] wram_q_ff, cart_q_ff, prg_q_ff, pat_q_ff, nt_q_ff, pal_q_ff;

   logic        rd_en;
   logic [15:0] rd_addr;
   logic        cpu_we, ppu_we, oam_we;
   logic [7:0]  oam_wa, oam_wd;
   logic [7:0]  cpu_byte, ppu_byte;
   logic        out_free;
   logic [15:0] latch_step;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   assign rd_en   = ((state_ff == ST_IDLE) && req_valid) || (state_ff == ST_DMA);
   assign rd_addr = (state_ff == ST_DMA) ? {cur_ff.wdata, dma_cnt_ff[7:0]}
                                         : req_payload.addr;
   assign latch_step = latch_ff + (ppu_ff[PREG_CTRL][2] ? 16'd32 : 16'd1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Stores: write at the current request, registered read of the issued address
   always_ff @(posedge clock) begin
      if (cpu_we && cpu_region(cur_ff.addr) == RG_WRAM)
         wram_mem[cur_ff.addr[WRAM_AW-1:0]] <= cur_ff.wdata;
      if (cpu_we && cpu_region(cur_ff.addr) == RG_CART)
         cart_mem[cur_ff.addr[CART_AW-1:0]] <= cur_ff.wdata;
      if (cpu_we && cpu_region(cur_ff.addr) == RG_PRG)
         prg_mem[prg_index(cur_ff.addr, banks_ff)] <= cur_ff.wdata;
      if (rd_en) begin
         wram_q_ff  <= wram_mem[rd_addr[WRAM_AW-1:0]];
         cart_q_ff  <= cart_mem[rd_addr[CART_AW-1:0]];
         prg_q_ff   <= prg_mem[prg_index(rd_addr, banks_ff)];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (ppu_we && ppu_region(latch_ff) == PR_PAT)
         pat_mem[latch_ff[PAT_AW-1:0]] <= cur_ff.wdata;
      if (ppu_we && ppu_region(latch_ff) == PR_NT)
         nt_mem[latch_ff[NT_AW-1:0]] <= cur_ff.wdata;
      if (ppu_we && ppu_region(latch_ff) == PR_PAL)
         pal_mem[latch_ff[PAL_AW-1:0]] <= cur_ff.wdata;
      if (rd_en) begin
         pat_q_ff <= pat_mem[latch_ff[PAT_AW-1:0]];
         nt_q_ff  <= nt_mem[latch_ff[NT_AW-1:0]];
         pal_q_ff <= pal_mem[latch_ff[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (oam_we)
         oam_mem[oam_wa] <= oam_wd;
   end

   always_comb begin
      case (cpu_region(rd_addr_ff))
         RG_WRAM: cpu_byte = wram_q_ff;
         RG_PPU:  cpu_byte = ppu_ff[rd_addr_ff[2:0]];
         RG_IO:   cpu_byte = io_ff[rd_addr_ff[4:0]];
         RG_CART: cpu_byte = cart_q_ff;
         RG_PRG:  cpu_byte = prg_q_ff;
         default: cpu_byte = 8'h00;
      endcase
      case (ppu_region(latch_ff))
         PR_PAT:  ppu_byte = pat_q_ff;
         PR_NT:   ppu_byte = nt_q_ff;
         PR_PAL:  ppu_byte = pal_q_ff;
         default: ppu_byte = 8'h00;
      endcase
   end

   always_comb begin
      logic [2:0] r;
      logic       go_dma;
      logic [7:0] rd;
      state_in      = state_ff;
      cur_in        = cur_ff;
      ppu_in        = ppu_ff;
      io_in         = io_ff;
      latch_in      = latch_ff;
      pad_byte_in   = pad_byte_ff;
      pad_cnt_in    = pad_cnt_ff;
      pad_strobe_in = pad_strobe_ff;
      nmi_flag_in   = nmi_flag_ff;
      nmi_en_in     = nmi_en_ff;
      dma_cnt_in    = dma_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      cpu_we        = 1'b0;
      ppu_we        = 1'b0;
      oam_we        = 1'b0;
      oam_wa        = ppu_ff[PREG_OAMADR];
      oam_wd        = cur_ff.wdata;
      r             = cur_ff.addr[2:0];
      go_dma        = 1'b0;
      rd            = 8'h00;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_payload;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               case (cur_ff.cmd)
                  CMD_READ: begin
                     if (cpu_region(cur_ff.addr) == RG_PPU) begin
                        if (r == PREG_STATUS) begin
                           rd = ppu_ff[PREG_STATUS];
                           ppu_in[PREG_STATUS] = {1'b0, ppu_ff[PREG_STATUS][6:0]};
                           nmi_flag_in = 1'b0;
                           latch_in    = 16'h0000;
                        end else if (r == PREG_DATA) begin
                           rd       = ppu_byte;
                           latch_in = latch_step;
                        end else begin
                           rd = ppu_ff[r];
                        end
                     end else if (cur_ff.addr == ADDR_PAD) begin
                        if (pad_strobe_ff) begin
                           pad_byte_in = cur_ff.buttons;
                           pad_cnt_in  = 4'd0;
                        end
                        if (pad_cnt_in > 4'd7) begin
                           rd = 8'h01;
                        end else begin
                           rd = {7'd0, pad_byte_in[pad_cnt_in[2:0]]};
                           if (!pad_strobe_ff)
                              pad_cnt_in = pad_cnt_in + 4'd1;
                        end
                     end else begin
                        rd = cpu_byte;
                     end
                  end
                  CMD_WRITE: begin
                     cpu_we = 1'b1;
                     case (cpu_region(cur_ff.addr))
                        RG_PPU: begin
                           ppu_in[r] = cur_ff.wdata;
                           case (r)
                              PREG_CTRL: nmi_en_in = cur_ff.wdata[7];
                              PREG_OAMDAT: begin
                                 oam_we = 1'b1;
                                 ppu_in[PREG_OAMADR] = ppu_ff[PREG_OAMADR] + 8'd1;
                              end
                              PREG_ADDR: latch_in = {latch_ff[7:0], cur_ff.wdata};
                              PREG_DATA: begin
                                 ppu_we   = 1'b1;
                                 latch_in = latch_step;
                              end
                              default: ;
                           endcase
                        end
                        RG_IO: begin
                           io_in[cur_ff.addr[4:0]] = cur_ff.wdata;
                           if (cur_ff.addr == ADDR_OAM_DMA)
                              go_dma = 1'b1;
                           if (cur_ff.addr == ADDR_PAD) begin
                              if (cur_ff.wdata[0]) begin
                                 pad_byte_in = cur_ff.buttons;
                                 pad_cnt_in  = 4'd0;
                              end
                              pad_strobe_in = cur_ff.wdata[0];
                           end
                        end
                        default: ;
                     endcase
                  end
                  CMD_VBLANK: begin
                     ppu_in[PREG_STATUS] = ppu_ff[PREG_STATUS] | 8'h80;
                     nmi_flag_in = 1'b1;
                  end
                  default: ;
               endcase
               if (go_dma) begin
                  dma_cnt_in = 9'd0;
                  state_in   = ST_DMA;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.rdata       = rd;
                  rsp_in.stall_cycles = 10'd0;
                  rsp_in.nmi_enable  = nmi_en_in;
                  rsp_in.nmi_pending = nmi_flag_in;
                  state_in           = ST_IDLE;
               end
            end
         end
         ST_DMA: begin
            // Write back the byte read last cycle, issue the next read
            oam_wa = dma_cnt_ff[7:0] - 8'd1;
            oam_wd = cpu_byte;
            oam_we = (dma_cnt_ff != 9'd0);
            dma_cnt_in = dma_cnt_ff + 9'd1;
            if (dma_cnt_ff[8]) begin
               rsp_valid_in        = 1'b1;
               rsp_in.rdata        = 8'h00;
               rsp_in.stall_cycles = 10'(DMA_STALL_CYCLES);
               rsp_in.nmi_enable   = nmi_en_ff;
               rsp_in.nmi_pending  = nmi_flag_ff;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ppu_ff        <= '{default: 8'h00};
         io_ff         <= '{default: 8'h00};
         latch_ff      <= 16'h0000;
         pad_byte_ff   <= 8'h00;
         pad_cnt_ff    <= 4'd0;
         pad_strobe_ff <= 1'b0;
         nmi_flag_ff   <= 1'b0;
         nmi_en_ff     <= 1'b0;
         banks_ff      <= 2'd2;
         dma_cnt_ff    <= 9'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ppu_ff        <= ppu_in;
         io_ff         <= io_in;
         latch_ff      <= latch_in;
         pad_byte_ff   <= pad_byte_in;
         pad_cnt_ff    <= pad_cnt_in;
         pad_strobe_ff <= pad_strobe_in;
         nmi_flag_ff   <= nmi_flag_in;
         nmi_en_ff     <= nmi_en_in;
         dma_cnt_ff    <= dma_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready)
            banks_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   a_dma_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DMA |-> !rsp_valid_ff)
      else $error("response pending during OAM DMA");

   a_stall_from_dma: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_ff.stall_cycles != 10'd0 |-> $past(state_ff) == ST_DMA)
      else $error("stall charged without OAM DMA");

   a_pad_cnt: assert property (@(posedge clock) disable iff (reset)
      pad_cnt_ff <= 4'd8)
      else $error("controller shift count out of range");

   a_exec_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> $past(state_ff) == ST_IDLE || $past(state_ff) == ST_EXEC)
      else $error("execute entered without accept");

endmodule

// ----- test/ccb_bus_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_bus_checker
// Watches the request, response and register channels of the CPU bus block,
// keeps its own copy of the bus, PPU and controller state, predicts each
// response and compares it field by field in order.
// ----------------------------------------------------------------------------
module ccb_bus_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  ccb_pkg::ccb_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ccb_pkg::ccb_rsp_type rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [1:0]           csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   import ccb_pkg::*;

   logic [7:0]  wram_mem [INTERNAL_RAM_BYTES];
   logic [7:0]  preg_file [8];
   logic [7:0]  io_regs [32];
   logic [7:0]  cart_mem [8192];
   logic [7:0]  prg_mem [2 * PROGRAM_BANK_BYTES];
   logic [7:0]  pat_mem [8192];
   logic [7:0]  nt_mem [4096];
   logic [7:0]  pal_mem [32];
   logic [7:0]  oam_mem [256];
   logic [15:0] vram_ptr;
   logic [7:0]  pad_bits;
   logic [3:0]  pad_pos;
   logic        pad_latch_on;
   logic        vblank_flag;
   logic        nmi_on;
   logic [1:0]  bank_count;

   ccb_rsp_type rsp_fifo [$];

   function automatic logic [14:0] prg_slot(input logic [15:0] a);
      logic [14:0] s;
      s = a[14:0];
      if (!bank_count[1]) s[14] = 1'b0;
      return s;
   endfunction

   function automatic logic [7:0] bus_peek(input logic [15:0] a);
      logic [7:0] v;
      if (a < 16'h2000)      v = wram_mem[a[10:0]];
      else if (a < 16'h4000) v = preg_file[a[2:0]];
      else if (a < 16'h4020) v = io_regs[a[4:0]];
      else if (!a[15])       v = cart_mem[a[12:0]];
      else                   v = prg_mem[prg_slot(a)];
      return v;
   endfunction

   task automatic bus_poke(input logic [15:0] a, input logic [7:0] v);
      if (a < 16'h2000)      wram_mem[a[10:0]] = v;
      else if (a < 16'h4000) preg_file[a[2:0]] = v;
      else if (a < 16'h4020) io_regs[a[4:0]] = v;
      else if (!a[15])       cart_mem[a[12:0]] = v;
      else                   prg_mem[prg_slot(a)] = v;
   endtask

   function automatic logic [7:0] vram_peek(input logic [15:0] p);
      logic [13:0] l;
      logic [7:0]  v;
      l = p[13:0];
      if (l < 14'h2000)      v = pat_mem[l[12:0]];
      else if (l < 14'h3F00) v = nt_mem[l[11:0]];
      else                   v = pal_mem[l[4:0]];
      return v;
   endfunction

   task automatic vram_poke(input logic [15:0] p, input logic [7:0] v);
      logic [13:0] l;
      l = p[13:0];
      if (l < 14'h2000)      pat_mem[l[12:0]] = v;
      else if (l < 14'h3F00) nt_mem[l[11:0]] = v;
      else                   pal_mem[l[4:0]] = v;
   endtask

   task automatic advance_vram_ptr();
      vram_ptr = vram_ptr + (preg_file[PREG_CTRL][2] ? 16'd32 : 16'd1);
   endtask

   task automatic run_read(input ccb_req_type q, output logic [7:0] rd);
      logic [2:0] r;
      r = q.addr[2:0];
      if (q.addr >= 16'h2000 && q.addr < 16'h4000) begin
         rd = preg_file[r];
         if (r == PREG_STATUS) begin
            preg_file[PREG_STATUS] = rd & 8'h7F;
            vblank_flag = 1'b0;
            vram_ptr = '0;
         end else if (r == PREG_DATA) begin
            rd = vram_peek(vram_ptr);
            advance_vram_ptr();
         end
      end else if (q.addr == ADDR_PAD) begin
         if (pad_latch_on) begin
            pad_bits = q.buttons;
            pad_pos = '0;
         end
         if (pad_pos > 4'd7) begin
            rd = 8'd1;
         end else begin
            rd = {7'd0, pad_bits[pad_pos[2:0]]};
            if (!pad_latch_on) pad_pos = pad_pos + 4'd1;
         end
      end else begin
         rd = bus_peek(q.addr);
      end
   endtask

   task automatic run_write(input ccb_req_type q, output logic [9:0] stall);
      logic [15:0] src;
      stall = '0;
      bus_poke(q.addr, q.wdata);
      if (q.addr >= 16'h2000 && q.addr < 16'h4000) begin
         case (q.addr[2:0])
            PREG_CTRL: nmi_on = q.wdata[7];
            PREG_OAMDAT: begin
               oam_mem[preg_file[PREG_OAMADR]] = q.wdata;
               preg_file[PREG_OAMADR] = preg_file[PREG_OAMADR] + 8'd1;
            end
            PREG_ADDR: vram_ptr = {vram_ptr[7:0], q.wdata};
            PREG_DATA: begin
               vram_poke(vram_ptr, q.wdata);
               advance_vram_ptr();
            end
            default: ;
         endcase
      end else if (q.addr == ADDR_OAM_DMA) begin
         src = {q.wdata, 8'h00};
         for (int i = 0; i < 256; i++) oam_mem[i] = bus_peek(src + 16'(i));
         stall = 10'(DMA_STALL_CYCLES);
      end else if (q.addr == ADDR_PAD) begin
         if (q.wdata[0]) begin
            pad_bits = q.buttons;
            pad_pos = '0;
         end
         pad_latch_on = q.wdata[0];
      end
   endtask

   task automatic predict_bus_access(input ccb_req_type q, output ccb_rsp_type r);
      logic [7:0]  rd;
      logic [9:0]  st;
      rd = '0;
      st = '0;
      if (q.cmd == CMD_READ) begin
         run_read(q, rd);
      end else if (q.cmd == CMD_WRITE) begin
         run_write(q, st);
      end else if (q.cmd == CMD_VBLANK) begin
         preg_file[PREG_STATUS][7] = 1'b1;
         vblank_flag = 1'b1;
      end
      r.rdata        = rd;
      r.stall_cycles = st;
      r.nmi_enable   = nmi_on;
      r.nmi_pending  = vblank_flag;
   endtask

   always @(posedge clock) begin
      ccb_rsp_type want;
      ccb_rsp_type got;
      if (reset) begin
         foreach (preg_file[i]) preg_file[i] = '0;
         foreach (io_regs[i]) io_regs[i] = '0;
         vram_ptr     = '0;
         pad_bits     = '0;
         pad_pos      = '0;
         pad_latch_on = 1'b0;
         vblank_flag  = 1'b0;
         nmi_on       = 1'b0;
         bank_count   = 2'd2;
         fail_count   = 0;
         rsp_fifo.delete();
      end else begin
         if (csr_valid && csr_ready) bank_count = csr_wdata;
         // retire the oldest request before taking a new one
         if (rsp_valid && !rsp_stall) begin
            if (rsp_fifo.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = rsp_fifo.pop_front();
               if (rsp_payload.rdata !== want.rdata) begin
                  $error("rdata expected %0h got %0h", want.rdata, rsp_payload.rdata);
                  fail_count++;
               end
               if (rsp_payload.stall_cycles !== want.stall_cycles) begin
                  $error("stall_cycles expected %0d got %0d", want.stall_cycles,
                         rsp_payload.stall_cycles);
                  fail_count++;
               end
               if (rsp_payload.nmi_enable !== want.nmi_enable) begin
                  $error("nmi_enable expected %0b got %0b", want.nmi_enable,
                         rsp_payload.nmi_enable);
                  fail_count++;
               end
               if (rsp_payload.nmi_pending !== want.nmi_pending) begin
                  $error("nmi_pending expected %0b got %0b", want.nmi_pending,
                         rsp_payload.nmi_pending);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_bus_access(req_payload, got);
            rsp_fifo.push_back(got);
         end
      end
      pending = rsp_fifo.size();
   end

endmodule

// ----- test/tb_console_cpu_bus_with_ppu_ports.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_cpu_bus_with_ppu_ports
// Drives directed and random CPU bus traffic (RAM, PPU ports, controller,
// OAM DMA, program banks) with random gaps and response stalls; a checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_console_cpu_bus_with_ppu_ports;
   import ccb_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_REQUESTS = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ccb_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ccb_rsp_type rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_wdata = 2'd2;

   int fail_count;
   int pending;
   int cycles = 0;
   int sent = 0;
   bit idle_on = 1'b1;
   bit long_hold = 1'b0;

   // Stimulus-side view of what has been written, so no read hits a cell
   // that was never written.
   bit          wram_seen [INTERNAL_RAM_BYTES];
   bit          cart_seen [8192];
   bit          prg_seen [2 * PROGRAM_BANK_BYTES];
   bit          vram_seen [16384];
   logic [15:0] vram_ptr = '0;
   bit          step_by_row = 1'b0;
   logic [1:0]  cur_banks = 2'd2;

   console_cpu_bus_with_ppu_ports dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   ccb_bus_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response side: short random stalls, occasional long ones, one very long hold
   always @(posedge clock) begin
      int hold_left;
      int burst_left;
      bit hold_taken;
      if (long_hold && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int vram_key(input logic [15:0] p);
      logic [13:0] l;
      l = p[13:0];
      if (l < 14'h2000)      return int'(l);
      else if (l < 14'h3F00) return 'h2000 | int'(l[11:0]);
      else                   return 'h3F00 | int'(l[4:0]);
   endfunction

   function automatic int prg_key(input logic [15:0] a);
      return cur_banks[1] ? int'(a[14:0]) : int'(a[13:0]);
   endfunction

   function automatic bit cell_known(input logic [15:0] a);
      if (a < 16'h2000)      return wram_seen[a[10:0]];
      else if (a < 16'h4000) return (a[2:0] != PREG_DATA) || vram_seen[vram_key(vram_ptr)];
      else if (a < 16'h4020) return 1'b1;
      else if (!a[15])       return cart_seen[a[12:0]];
      else                   return prg_seen[prg_key(a)];
   endfunction

   function automatic bit page_known(input logic [7:0] pg);
      for (int i = 0; i < 256; i++) begin
         if (!cell_known({pg, 8'(i)}) && !({pg, 8'(i)} >= 16'h2000 &&
                                             {pg, 8'(i)} < 16'h4000))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic advance_ptr();
      vram_ptr = vram_ptr + (step_by_row ? 16'd32 : 16'd1);
   endtask

   task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
                               input logic [7:0] wdata);
      int gap;
      ccb_req_type q;
      // turn a read of a never-written cell into a write of it
      if (cmd == CMD_READ && !cell_known(addr)) cmd = CMD_WRITE;
      if (cmd == CMD_WRITE && addr == ADDR_OAM_DMA && !page_known(wdata))
         wdata = 8'h20 | 8'($urandom_range(0, 31));
      if (cmd == CMD_WRITE) begin
         if (addr < 16'h2000) wram_seen[addr[10:0]] = 1'b1;
         else if (addr >= 16'h4020 && !addr[15]) cart_seen[addr[12:0]] = 1'b1;
         else if (addr[15]) prg_seen[prg_key(addr)] = 1'b1;
         else if (addr < 16'h4000) begin
            case (addr[2:0])
               PREG_CTRL: step_by_row = wdata[2];
               PREG_ADDR: vram_ptr = {vram_ptr[7:0], wdata};
               PREG_DATA: begin
                  vram_seen[vram_key(vram_ptr)] = 1'b1;
                  advance_ptr();
               end
               default: ;
            endcase
         end
      end else if (cmd == CMD_READ && addr >= 16'h2000 && addr < 16'h4000) begin
         if (addr[2:0] == PREG_STATUS) vram_ptr = '0;
         else if (addr[2:0] == PREG_DATA) advance_ptr();
      end
      q.cmd = cmd;
      q.addr = addr;
      q.wdata = wdata;
      q.buttons = 8'($urandom_range(0, 255));
      gap = 0;
      if (idle_on) begin
         gap = $urandom_range(0, 99);
         gap = (gap < 55) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= q;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_banks(input logic [1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      cur_banks = v;
   endtask

   task automatic ppu_burst();
      logic [7:0] hi;
      logic [7:0] lo;
      int n;
      case ($urandom_range(0, 4))
         0: hi = 8'($urandom_range(0, 1));
         1: hi = 8'h2C;
         2: hi = 8'h3F;
         3: hi = 8'hFF;
         default: hi = 8'($urandom_range(0, 255));
      endcase
      lo = 8'($urandom_range(0, 255)) & 8'hE7;
      n = $urandom_range(1, 6);
      send_request(CMD_WRITE, 16'h2000 | 16'($urandom_range(0, 1023)) << 3,
                   8'($urandom_range(0, 255)));
      send_request(CMD_WRITE, 16'h2006, hi);
      send_request(CMD_WRITE, 16'h2006, lo);
      repeat (n) send_request(CMD_WRITE, 16'h3FFF & ~16'h0, 8'($urandom_range(0, 255)));
      send_request(CMD_WRITE, 16'h2006 | 16'($urandom_range(0, 1023)) << 3, hi);
      send_request(CMD_WRITE, 16'h2006, lo);
      repeat (n) send_request(CMD_READ, 16'h2007 | 16'($urandom_range(0, 1023)) << 3, 8'h00);
   endtask

   task automatic pad_sequence();
      send_request(CMD_WRITE, ADDR_PAD, 8'h01);
      if ($urandom_range(0, 1)) send_request(CMD_READ, ADDR_PAD, 8'h00);
      send_request(CMD_WRITE, ADDR_PAD, 8'hFE);
      repeat ($urandom_range(3, 10)) send_request(CMD_READ, ADDR_PAD, 8'h00);
   endtask

   task automatic random_request();
      logic [15:0] a;
      logic [1:0]  cmd;
      int pick;
      pick = $urandom_range(0, 99);
      cmd = $urandom_range(0, 2) == 0 ? CMD_WRITE : CMD_READ;
      if (pick < 18)      a = 16'($urandom_range(0, 3)) << 11 | 16'($urandom_range(0, 31));
      else if (pick < 30) a = 16'h2000 | 16'($urandom_range(0, 8191));
      else if (pick < 36) a = 16'h4000 | 16'($urandom_range(0, 31));
      else if (pick < 44) a = 16'h4020 + 16'($urandom_range(0, 16351)) & 16'hFE3F;
      else if (pick < 54) a = 16'h8000 | 16'($urandom_range(0, 3)) << 13 |
                               16'($urandom_range(0, 31));
      else if (pick < 60) begin
         a = 16'($urandom_range(0, 65535));
         cmd = CMD_WRITE;
      end else if (pick < 66) begin
         send_request(CMD_VBLANK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
         return;
      end else if (pick < 70) begin
         send_request(CMD_WRITE, ADDR_OAM_DMA, 8'($urandom_range(0, 255)));
         return;
      end else if (pick < 88) begin
         ppu_burst();
         return;
      end else begin
         pad_sequence();
         return;
      end
      if (a >= 16'h4020 && a < 16'h4040) a = a;
      send_request(cmd, a, 8'($urandom_range(0, 255)));
   endtask

   task automatic random_phase(input int count);
      int stop;
      stop = sent + count;
      while (sent < stop) random_request();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_banks(2'd2);

      // directed: status, vblank, PPU ports, mirrors, wrap, OAM, DMA, pad
      send_request(CMD_READ,   16'h2002, 8'h00);
      send_request(CMD_VBLANK, 16'h0000, 8'h00);
      send_request(CMD_READ,   16'h3FFA, 8'h00);
      send_request(CMD_WRITE,  16'h2000, 8'h84);
      send_request(CMD_WRITE,  16'h2006, 8'h2C);
      send_request(CMD_WRITE,  16'h2006, 8'h00);
      send_request(CMD_WRITE,  16'h2007, 8'hAB);
      send_request(CMD_WRITE,  16'h2006, 8'h2C);
      send_request(CMD_WRITE,  16'h2006, 8'h00);
      send_request(CMD_READ,   16'h2007, 8'h00);
      send_request(CMD_WRITE,  16'h2008, 8'h00);
      send_request(CMD_WRITE,  16'h2006, 8'h7F);
      send_request(CMD_WRITE,  16'h2006, 8'hFF);
      send_request(CMD_WRITE,  16'h2007, 8'h5A);
      send_request(CMD_WRITE,  16'h0000, 8'hFF);
      send_request(CMD_READ,   16'h1800, 8'h00);
      send_request(CMD_WRITE,  16'hFFFF, 8'h00);
      send_request(CMD_READ,   16'hFFFF, 8'h00);
      send_request(CMD_WRITE,  16'h4020, 8'h3C);
      send_request(CMD_READ,   16'h6020, 8'h00);
      send_request(CMD_WRITE,  16'h2003, 8'hFF);
      send_request(CMD_WRITE,  16'h2004, 8'h11);
      send_request(CMD_WRITE,  ADDR_OAM_DMA, 8'h20);
      pad_sequence();

      random_phase(RANDOM_REQUESTS / 4);
      wait_idle();
      write_banks(2'd1);
      // hold the response side off while requests keep coming
      long_hold = 1'b1;
      random_phase(RANDOM_REQUESTS / 4);
      wait_idle();
      write_banks(2'd3);
      idle_on = 1'b0;
      random_phase(RANDOM_REQUESTS / 8);
      idle_on = 1'b1;
      random_phase(RANDOM_REQUESTS / 8);
      wait_idle();
      write_banks(2'd0);
      random_phase(RANDOM_REQUESTS / 4);
      wait_idle();
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
